@@ hdl/ipv4_ethernet_tx_framer_core_macros.svh @@
// Assertion macros for the IPv4 Ethernet transmit framer.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef IPV4_ETHERNET_TX_FRAMER_CORE_MACROS_SVH
`define IPV4_ETHERNET_TX_FRAMER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TXF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TXF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TXF_ASSERT(label, prop, msg)
`define TXF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hdl/txf_pkg.sv @@
// Shared types and constants of the IPv4 Ethernet transmit framer.
// No dependencies; used by every module of the block.
`default_nettype none

package txf_pkg;

  localparam int FRAME_MAX = 1514;
  localparam int HDR_BYTES = 34;
  localparam int HDR_BITS  = 8 * HDR_BYTES;
  localparam int HCNT_W    = $clog2(HDR_BYTES);
  localparam int FLEN_W    = 14;
  localparam int SUM_W     = 19;
  localparam int CK_WORDS  = 7;

  localparam int QAW       = 2;
  localparam int QDEPTH    = 1 << QAW;
  localparam int QCNT_W    = QAW + 1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;

  localparam logic [1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [1:0] CFG_OWN_IP  = 2'd1;
  localparam logic [1:0] CFG_TTL     = 2'd2;

  localparam logic [7:0]  TTL_RESET   = 8'd64;
  localparam logic [15:0] ETHERTYPE   = 16'h0800;
  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] IP_HDR_LEN  = 16'd20;

  typedef struct packed {
    logic        req_type;
    logic [31:0] dest_ip;
    logic [7:0]  protocol;
    logic [11:0] pay_len;
    logic [47:0] next_hop_mac;
    logic        mac_valid;
    logic [7:0]  data_byte;
  } in_data_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [1:0] status;
  } out_data_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [7:0]  ttl_value;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR_BIG,
    CMD_ERR_NOFRAME
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] dest_ip;
    logic [7:0]  protocol;
    logic [11:0] plen;
    logic [47:0] dmac;
    logic [7:0]  dbyte;
    logic        last;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/txf_front.sv @@
// Front end of the framer: accepts requests, tracks the open frame and classifies each request.
// Depends on txf_pkg.
`default_nettype none

module txf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire txf_pkg::in_data_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output txf_pkg::cmd_t         q_wdata
);

  logic [11:0]               bytes_left_r;
  logic [11:0]               bytes_left_nxt;
  logic [txf_pkg::FLEN_W-1:0] frame_len;
  logic                      too_big;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign frame_len = txf_pkg::FLEN_W'(txf_pkg::HDR_BYTES)
                   + {{(txf_pkg::FLEN_W-12){1'b0}}, in_data.pay_len};
  assign too_big   = frame_len > txf_pkg::FLEN_W'(txf_pkg::FRAME_MAX);

  always_comb begin
    q_wdata         = '0;
    q_wdata.dest_ip = in_data.dest_ip;
    q_wdata.protocol = in_data.protocol;
    q_wdata.plen    = in_data.pay_len;
    q_wdata.dmac    = in_data.mac_valid ? in_data.next_hop_mac : txf_pkg::MAC_BCAST;
    q_wdata.dbyte   = in_data.data_byte;
    bytes_left_nxt  = bytes_left_r;
    if (in_data.req_type == txf_pkg::REQ_START) begin
      // A start request always abandons whatever frame was open.
      if (too_big) begin
        q_wdata.kind   = txf_pkg::CMD_ERR_BIG;
        bytes_left_nxt = '0;
      end else begin
        q_wdata.kind   = txf_pkg::CMD_HDR;
        q_wdata.last   = (in_data.pay_len == '0);
        bytes_left_nxt = in_data.pay_len;
      end
    end else if (bytes_left_r == '0) begin
      q_wdata.kind = txf_pkg::CMD_ERR_NOFRAME;
    end else begin
      q_wdata.kind   = txf_pkg::CMD_DATA;
      q_wdata.last   = (bytes_left_r == 12'd1);
      bytes_left_nxt = bytes_left_r - 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else if (q_push) begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/txf_queue.sv @@
// Short command queue between the framer front end and back end.
// Depends on txf_pkg and the assertion macro header.
`default_nettype none
`include "ipv4_ethernet_tx_framer_core_macros.svh"

module txf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire txf_pkg::cmd_t wdata,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output txf_pkg::cmd_t      head
);

  txf_pkg::cmd_t                mem [txf_pkg::QDEPTH];
  logic [txf_pkg::QAW-1:0]      wr_ptr_r;
  logic [txf_pkg::QAW-1:0]      rd_ptr_r;
  logic [txf_pkg::QCNT_W-1:0]   count_r;

  assign full      = (count_r == txf_pkg::QCNT_W'(txf_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `TXF_ASSERT(a_no_overflow, !(push && full), "queue written while full")
  `TXF_ASSERT(a_no_underflow, !(pop && !not_empty), "queue read while empty")
  `TXF_ASSERT(a_count_bound, count_r <= txf_pkg::QCNT_W'(txf_pkg::QDEPTH),
              "queue count out of range")

endmodule

`default_nettype wire

@@ hdl/txf_back.sv @@
// Back end of the framer: turns queued commands into frame bytes, with the header checksum
// accumulated while the first header bytes go out. Depends on txf_pkg and the macro header.
`default_nettype none
`include "ipv4_ethernet_tx_framer_core_macros.svh"

module txf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire txf_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire txf_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output txf_pkg::out_data_t out_data
);

  localparam logic [txf_pkg::HCNT_W-1:0] HdrLast = txf_pkg::HCNT_W'(txf_pkg::HDR_BYTES - 1);

  logic                          out_valid_r;
  txf_pkg::out_data_t            out_data_r;
  txf_pkg::out_data_t            out_data_nxt;
  logic [txf_pkg::HCNT_W-1:0]    hcnt_r;
  logic [txf_pkg::SUM_W-1:0]     sum_r;
  logic                          load;
  logic [15:0]                   ip_len;
  logic [15:0]                   ck_word;
  logic [16:0]                   fold1;
  logic [15:0]                   fold2;
  logic [15:0]                   checksum;
  logic [txf_pkg::HDR_BITS-1:0]  hdr_w;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register refills whenever it is empty or being taken this cycle.
  assign load  = !out_valid_r || !out_stall;
  assign q_pop = load && q_valid && (q_head.kind != txf_pkg::CMD_HDR || hcnt_r == HdrLast);

  assign ip_len = txf_pkg::IP_HDR_LEN + {4'b0, q_head.plen};

  always_comb begin
    unique case (hcnt_r)
      txf_pkg::HCNT_W'(0): ck_word = {txf_pkg::VER_IHL, 8'h00};
      txf_pkg::HCNT_W'(1): ck_word = ip_len;
      txf_pkg::HCNT_W'(2): ck_word = {cfg.ttl_value, q_head.protocol};
      txf_pkg::HCNT_W'(3): ck_word = cfg.own_ip[31:16];
      txf_pkg::HCNT_W'(4): ck_word = cfg.own_ip[15:0];
      txf_pkg::HCNT_W'(5): ck_word = q_head.dest_ip[31:16];
      txf_pkg::HCNT_W'(6): ck_word = q_head.dest_ip[15:0];
      default:             ck_word = 16'h0000;
    endcase
  end

  // The sum of seven words stays below 2^19, so two end-around folds are enough.
  assign fold1    = {1'b0, sum_r[15:0]} + {14'b0, sum_r[18:16]};
  assign fold2    = fold1[15:0] + {15'b0, fold1[16]};
  assign checksum = ~fold2;

  // Identification and flags/fragment offset go out as four zero bytes.
  assign hdr_w = {q_head.dmac, cfg.own_mac, txf_pkg::ETHERTYPE, txf_pkg::VER_IHL, 8'h00,
                  ip_len, 32'h0000_0000, cfg.ttl_value, q_head.protocol, checksum,
                  cfg.own_ip, q_head.dest_ip};

  always_comb begin
    out_data_nxt = '0;
    unique case (q_head.kind)
      txf_pkg::CMD_HDR: begin
        out_data_nxt.frame_byte = hdr_w[txf_pkg::HDR_BITS - 1 - 8 * int'(hcnt_r) -: 8];
        out_data_nxt.frame_last = q_head.last && (hcnt_r == HdrLast);
        out_data_nxt.status     = txf_pkg::ST_OK;
      end
      txf_pkg::CMD_DATA: begin
        out_data_nxt.frame_byte = q_head.dbyte;
        out_data_nxt.frame_last = q_head.last;
        out_data_nxt.status     = txf_pkg::ST_OK;
      end
      txf_pkg::CMD_ERR_BIG: begin
        out_data_nxt.status = txf_pkg::ST_TOO_BIG;
      end
      txf_pkg::CMD_ERR_NOFRAME: begin
        out_data_nxt.status = txf_pkg::ST_NO_FRAME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hcnt_r      <= '0;
      sum_r       <= '0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid && q_head.kind == txf_pkg::CMD_HDR) begin
        if (hcnt_r == HdrLast) begin
          hcnt_r <= '0;
          sum_r  <= '0;
        end else begin
          hcnt_r <= hcnt_r + 1'b1;
          if (hcnt_r < txf_pkg::HCNT_W'(txf_pkg::CK_WORDS)) begin
            sum_r <= sum_r + {3'b000, ck_word};
          end
        end
      end
    end
  end

  `TXF_ASSERT(a_hdr_in_progress,
              (hcnt_r != '0) |-> (q_valid && q_head.kind == txf_pkg::CMD_HDR),
              "header count runs without a header command")
  `TXF_ASSERT(a_hcnt_range, hcnt_r <= HdrLast, "header byte count out of range")
  `TXF_ASSERT(a_hdr_done_clears,
              (q_pop && q_head.kind == txf_pkg::CMD_HDR) |=> (hcnt_r == '0 && sum_r == '0),
              "header state not cleared after the last header byte")

endmodule

`default_nettype wire

@@ hdl/ipv4_ethernet_tx_framer_core.sv @@
// Channel  Ports                                    Direction  Moves
// in       in_valid, in_stall, in_data              input      one start or payload request
// out      out_valid, out_stall, out_data           output     one frame byte or error status
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  input    one register write
//
// A start request that fits yields 34 header bytes, one too big an error status; every
// other request yields one result. One output byte register holds results; a four-entry
// command queue lets the front take requests while header bytes are still going out.
// Reset is synchronous and active low; ttl_value resets to 64, the addresses to zero.
// Either side may stall at any cycle; in_stall rises only when the command queue is full.
// Top level of the IPv4 Ethernet transmit framer; holds the configuration registers.
// Depends on txf_pkg, txf_front, txf_queue and txf_back.
`default_nettype none

module ipv4_ethernet_tx_framer_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire txf_pkg::in_data_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output txf_pkg::out_data_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [47:0]       cfg_data
);

  txf_pkg::cfg_t cfg_r;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  txf_pkg::cmd_t q_wdata;
  txf_pkg::cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_mac   <= '0;
      cfg_r.own_ip    <= '0;
      cfg_r.ttl_value <= txf_pkg::TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        txf_pkg::CFG_OWN_MAC: cfg_r.own_mac   <= cfg_data;
        txf_pkg::CFG_OWN_IP:  cfg_r.own_ip    <= cfg_data[31:0];
        txf_pkg::CFG_TTL:     cfg_r.ttl_value <= cfg_data[7:0];
        default:              cfg_r           <= cfg_r;
      endcase
    end
  end

  txf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  txf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  txf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sim/tb_ipv4_ethernet_tx_framer_core.sv @@
// Self-checking testbench for ipv4_ethernet_tx_framer_core: a directed table, then random
// frames under several flow-control patterns, checked byte by byte against a built-in model.
// Depends on txf_pkg and the RTL of the framer only.
`timescale 1ns / 100ps

module tb_ipv4_ethernet_tx_framer_core;

  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 38;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam txf_pkg::out_data_t NO_FRAME_RES = '{frame_byte: 8'h00, frame_last: 1'b0,
                                                  status: txf_pkg::ST_NO_FRAME};
  localparam txf_pkg::out_data_t TOO_BIG_RES  = '{frame_byte: 8'h00, frame_last: 1'b0,
                                                  status: txf_pkg::ST_TOO_BIG};

  typedef struct {
    txf_pkg::in_data_t  req;
    bit                 typed;
    txf_pkg::out_data_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  txf_pkg::in_data_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  txf_pkg::out_data_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = txf_pkg::CFG_OWN_MAC;
  logic [47:0]        cfg_data = '0;

  // Model state and register copies.
  logic [47:0] m_own_mac = '0;
  logic [31:0] m_own_ip = '0;
  logic [7:0]  m_ttl = txf_pkg::TTL_RESET;
  logic [11:0] m_left = '0;
  logic        m_open = 1'b0;

  txf_pkg::out_data_t pending[$];
  txf_pkg::out_data_t staged[$];
  dir_row_t           dir_tab[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;
  int gap_tab[4] = '{0, 72, 0, 17};
  int stall_tab[4] = '{0, 0, 72, 17};

  ipv4_ethernet_tx_framer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic txf_pkg::in_data_t rand_req();
    txf_pkg::in_data_t r;
    r.req_type     = 1'($urandom_range(1));
    r.dest_ip      = $urandom();
    r.protocol     = 8'($urandom_range(255));
    r.pay_len      = 12'($urandom_range(4095));
    r.next_hop_mac = rand48();
    r.mac_valid    = 1'($urandom_range(1));
    r.data_byte    = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic txf_pkg::in_data_t start_req(input logic [31:0] dst,
                                                  input logic [7:0] proto,
                                                  input logic [11:0] plen,
                                                  input logic [47:0] mac,
                                                  input logic mv);
    txf_pkg::in_data_t r;
    r = '0;
    r.req_type     = txf_pkg::REQ_START;
    r.dest_ip      = dst;
    r.protocol     = proto;
    r.pay_len      = plen;
    r.next_hop_mac = mac;
    r.mac_valid    = mv;
    return r;
  endfunction

  function automatic txf_pkg::in_data_t byte_req(input logic [7:0] b);
    txf_pkg::in_data_t r;
    r = '0;
    r.req_type  = txf_pkg::REQ_DATA;
    r.data_byte = b;
    return r;
  endfunction

  function automatic logic [15:0] ip_checksum(input logic [15:0] ip_len,
                                              input logic [7:0] proto,
                                              input logic [31:0] dst);
    logic [31:0] acc;
    acc = {txf_pkg::VER_IHL, 8'h00} + ip_len + {m_ttl, proto} + m_own_ip[31:16]
          + m_own_ip[15:0] + dst[31:16] + dst[15:0];
    while (acc[31:16] != 16'h0000)
      acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  // Computes the frame bytes one request produces and advances the model state.
  function automatic void frame_predict(input txf_pkg::in_data_t r);
    logic [txf_pkg::HDR_BITS-1:0] hdr;
    logic [47:0]        dmac;
    logic [15:0]        ip_len;
    txf_pkg::out_data_t o;
    if (r.req_type == txf_pkg::REQ_START) begin
      m_open = 1'b0;
      m_left = '0;
      if (txf_pkg::HDR_BYTES + r.pay_len > txf_pkg::FRAME_MAX) begin
        staged.push_back(TOO_BIG_RES);
      end else begin
        dmac   = r.mac_valid ? r.next_hop_mac : txf_pkg::MAC_BCAST;
        ip_len = txf_pkg::IP_HDR_LEN + {4'h0, r.pay_len};
        hdr = {dmac, m_own_mac, txf_pkg::ETHERTYPE, txf_pkg::VER_IHL, 8'h00, ip_len,
               32'h0000_0000, m_ttl, r.protocol, ip_checksum(ip_len, r.protocol, r.dest_ip),
               m_own_ip, r.dest_ip};
        for (int i = 0; i < txf_pkg::HDR_BYTES; i++) begin
          o.frame_byte = hdr[txf_pkg::HDR_BITS-1-8*i -: 8];
          o.frame_last = (r.pay_len == 0) && (i == txf_pkg::HDR_BYTES - 1);
          o.status     = txf_pkg::ST_OK;
          staged.push_back(o);
        end
        if (r.pay_len != 0) begin
          m_open = 1'b1;
          m_left = r.pay_len;
        end
      end
    end else if (!m_open || m_left == 0) begin
      staged.push_back(NO_FRAME_RES);
    end else begin
      m_left = m_left - 1'b1;
      o.frame_byte = r.data_byte;
      o.frame_last = (m_left == 0);
      o.status     = txf_pkg::ST_OK;
      staged.push_back(o);
      if (m_left == 0)
        m_open = 1'b0;
    end
  endfunction

  // Presents one request, holds it until accepted, then queues its expected bytes.
  task automatic drive_req(input txf_pkg::in_data_t req, input bit typed,
                           input txf_pkg::out_data_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    staged.delete();
    frame_predict(req);
    if (typed)
      pending.push_back(want);
    else
      foreach (staged[i])
        pending.push_back(staged[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      txf_pkg::CFG_OWN_MAC: m_own_mac = val;
      txf_pkg::CFG_OWN_IP:  m_own_ip = val[31:0];
      txf_pkg::CFG_TTL:     m_ttl = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [47:0] mac, input logic [47:0] ip,
                             input logic [47:0] ttl);
    write_reg(txf_pkg::CFG_OWN_MAC, mac);
    write_reg(txf_pkg::CFG_OWN_IP, ip);
    write_reg(txf_pkg::CFG_TTL, ttl);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; some truncated, some followed by a
  // stray payload byte, and a share of fully random requests.
  task automatic random_traffic(input int quota, input bit full_first);
    txf_pkg::in_data_t r;
    int sent;
    int plen;
    int nsend;
    int pick;
    bit first;
    sent  = 0;
    first = full_first;
    while (sent < quota) begin
      r = rand_req();
      if ($urandom_range(99) < 10) begin
        drive_req(r, 1'b0, '0);
        sent++;
      end else begin
        if ($urandom_range(19) == 0)
          drain();
        pick = $urandom_range(99);
        if (first)
          plen = txf_pkg::FRAME_MAX - txf_pkg::HDR_BYTES;
        else if (pick < 70)
          plen = $urandom_range(16);
        else if (pick < 85)
          plen = $urandom_range(200, 17);
        else if (pick < 87)
          plen = $urandom_range(txf_pkg::FRAME_MAX - txf_pkg::HDR_BYTES, 1400);
        else if (pick < 95)
          plen = $urandom_range(4095, txf_pkg::FRAME_MAX - txf_pkg::HDR_BYTES + 1);
        else
          plen = $urandom_range(4095);
        first = 1'b0;
        r.req_type = txf_pkg::REQ_START;
        r.pay_len  = plen[11:0];
        drive_req(r, 1'b0, '0);
        sent++;
        nsend = (txf_pkg::HDR_BYTES + plen > txf_pkg::FRAME_MAX) ? 0 : plen;
        if (nsend > 0 && $urandom_range(9) == 0)
          nsend = $urandom_range(nsend - 1);
        // Long frames are cut off at the end of the phase quota.
        if (nsend > quota - sent)
          nsend = quota - sent;
        repeat (nsend) begin
          r = rand_req();
          r.req_type = txf_pkg::REQ_DATA;
          drive_req(r, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(19) == 0) begin
          r = rand_req();
          r.req_type = txf_pkg::REQ_DATA;
          drive_req(r, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    txf_pkg::out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        fail_cnt++;
        if (fail_cnt < 20)
          $display("%0t: unexpected frame byte, expected none, got %h/%b/%0d", $time,
                   out_data.frame_byte, out_data.frame_last, out_data.status);
      end else begin
        want = pending.pop_front();
        if (out_data.frame_byte !== want.frame_byte) begin
          fail_cnt++;
          if (fail_cnt < 20)
            $display("%0t: frame_byte mismatch, expected %h, got %h", $time,
                     want.frame_byte, out_data.frame_byte);
        end
        if (out_data.frame_last !== want.frame_last) begin
          fail_cnt++;
          if (fail_cnt < 20)
            $display("%0t: frame_last mismatch, expected %b, got %b", $time,
                     want.frame_last, out_data.frame_last);
        end
        if (out_data.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt < 20)
            $display("%0t: status mismatch, expected %0d, got %0d", $time,
                     want.status, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed rows run with the register values left by reset.
    dir_tab.push_back('{byte_req(8'h00), 1'b1, NO_FRAME_RES});
    dir_tab.push_back('{start_req(32'h0000_0000, 8'h00, 12'd0, 48'h0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{start_req(32'hFFFF_FFFF, 8'hFF, 12'd1481, txf_pkg::MAC_BCAST, 1'b1),
                        1'b1, TOO_BIG_RES});
    dir_tab.push_back('{start_req(32'hFFFF_FFFF, 8'hFF, 12'd4095, txf_pkg::MAC_BCAST, 1'b1),
                        1'b1, TOO_BIG_RES});
    dir_tab.push_back('{byte_req(8'hFF), 1'b1, NO_FRAME_RES});
    dir_tab.push_back('{start_req(32'hC0A8_0001, 8'd17, 12'd1480, 48'h0, 1'b1), 1'b0, '0});
    dir_tab.push_back('{byte_req(8'h5A), 1'b0, '0});
    // A new start request abandons the frame still waiting for payload.
    dir_tab.push_back('{start_req(32'h0A00_0002, 8'd6, 12'd2, 48'h0200_0000_0001, 1'b1),
                        1'b0, '0});
    dir_tab.push_back('{byte_req(8'h00), 1'b0, '0});
    dir_tab.push_back('{byte_req(8'hFF), 1'b0, '0});
    dir_tab.push_back('{byte_req(8'hA5), 1'b1, NO_FRAME_RES});
    dir_tab.push_back('{start_req(32'h7F00_0001, 8'd1, 12'd1, txf_pkg::MAC_BCAST, 1'b0),
                        1'b0, '0});
    dir_tab.push_back('{byte_req(8'h3C), 1'b0, '0});
    dir_tab.push_back('{start_req(32'hFFFF_FFFF, 8'hFF, 12'd0, txf_pkg::MAC_BCAST, 1'b1),
                        1'b0, '0});
    dir_tab.push_back('{start_req(32'h8000_0000, 8'h80, 12'd1, 48'h8000_0000_0000, 1'b1),
                        1'b0, '0});
    dir_tab.push_back('{byte_req(8'h80), 1'b0, '0});
    dir_tab.push_back('{start_req(32'h5555_AAAA, 8'h55, 12'h555, 48'h5555_AAAA_5555, 1'b1),
                        1'b0, '0});
    dir_tab.push_back('{start_req(32'hAAAA_5555, 8'hAA, 12'h2AA, 48'hAAAA_5555_AAAA, 1'b1),
                        1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k])
      drive_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        load_config(txf_pkg::MAC_BCAST, txf_pkg::MAC_BCAST, txf_pkg::MAC_BCAST);
      end else if (ph == 1) begin
        write_reg(CFG_SPARE, rand48());
        load_config(48'h0, 48'h0, 48'h0);
      end else begin
        load_config(rand48(), rand48(), rand48());
      end
      gap_pct   = gap_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      random_traffic(PHASE_ITEMS, ph == 3);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
